FILE: design/ciphertext_autokey_stream_cipher_defines.svh
// assertion macros shared by the checker
`ifndef CIPHERTEXT_AUTOKEY_STREAM_CIPHER_DEFINES_SVH
`define CIPHERTEXT_AUTOKEY_STREAM_CIPHER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CAK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CAK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cak_pkg.sv
package cak_pkg;

  // field widths
  localparam int unsigned KEY_INDEX_W = 6;
  localparam int unsigned LETTER_W    = 7;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned VAL_W       = 5;
  // wide enough to hold any key length up to the largest ring
  localparam int unsigned LEN_W       = 9;

  // ring size default
  localparam int unsigned KEY_SLOTS_DEF = 64;

  // alphabet constants
  localparam int unsigned ALPHA_COUNT = 26;
  localparam int unsigned LOWER_BASE  = 97;
  localparam int unsigned UPPER_BASE  = 65;

  // reciprocal of 26 in 13 fractional bits, rounded down
  localparam int unsigned RECIP_SHIFT = 13;
  localparam int unsigned RECIP_26    = 315;

  // result queue depth
  localparam int unsigned OUTQ_DEPTH = 4;

  // key length after reset
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

  // request codes
  typedef enum logic {
    REQ_LOAD    = 1'b0,
    REQ_ENCRYPT = 1'b1
  } req_type_e;

  // result item handed from the engine to the queue
  typedef struct packed {
    logic                valid;
    logic [LETTER_W-1:0] cipher_letter;
  } push_t;

  // letter code to 0..25, taken as (code - 97) mod 26
  function automatic logic [VAL_W-1:0] letter_value(input logic [LETTER_W-1:0] code);
    logic [7:0]  x;
    logic [15:0] prod;
    logic [2:0]  q;
    logic [7:0]  r;
    x    = 8'(code) + 8'(ALPHA_COUNT * 4 - LOWER_BASE);
    prod = 16'(x) * 16'(RECIP_26);
    q    = prod[RECIP_SHIFT +: 3];
    r    = x - 8'(q) * 8'(ALPHA_COUNT);
    if (r >= 8'(ALPHA_COUNT)) begin
      r = r - 8'(ALPHA_COUNT);
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

FILE: design/cak_req_if.sv
interface cak_req_if import cak_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [KEY_INDEX_W-1:0] key_index;
  logic [LETTER_W-1:0]    letter;

  modport source (output valid, output req_type, output key_index, output letter,
                  input ready);
  modport sink   (input valid, input req_type, input key_index, input letter,
                  output ready);
endinterface

FILE: design/cak_res_if.sv
interface cak_res_if import cak_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] cipher_letter;

  modport source (output valid, output cipher_letter, input ready);
  modport sink   (input valid, input cipher_letter, output ready);
endinterface

FILE: design/cak_keyram.sv
module cak_keyram import cak_pkg::*; #(
  parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF,
  localparam int unsigned AddrW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [VAL_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [VAL_W-1:0] wr_data_i
);

  logic [VAL_W-1:0] mem [KEY_SLOTS];
  logic [VAL_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/cak_engine.sv
module cak_engine import cak_pkg::*; #(
  parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF,
  localparam int unsigned AddrW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   accept_i,
  input  logic                   req_type_i,
  input  logic [KEY_INDEX_W-1:0] key_index_i,
  input  logic [LETTER_W-1:0]    letter_i,
  output logic                   rd_en_o,
  output logic [AddrW-1:0]       rd_addr_o,
  input  logic [VAL_W-1:0]       rd_data_i,
  output logic                   wr_en_o,
  output logic [AddrW-1:0]       wr_addr_o,
  output logic [VAL_W-1:0]       wr_data_o,
  output logic                   inflight_o,
  output push_t                  push_o
);

  logic [CFG_W-1:0] key_length_q;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len_eff;
  logic [AddrW-1:0] pos_use;
  logic [LEN_W-1:0] pos_inc;
  logic [AddrW-1:0] pos_nxt;
  logic [LEN_W-1:0] idx_ext;
  logic             is_enc;

  logic             s1_valid_q;
  logic             s1_enc_q;
  logic             s1_wok_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [VAL_W-1:0] s1_val_q;

  logic             fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic [VAL_W-1:0] fwd_data_q;

  logic [VAL_W-1:0] key_val;
  logic [VAL_W:0]   sum_raw;
  logic [VAL_W-1:0] sum;

  // key length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      key_length_q <= cfg_wdata_i;
    end
  end

  // effective length: zero means one, saturate at the ring size
  always_comb begin
    if (key_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(key_length_q) > LEN_W'(KEY_SLOTS)) begin
      len_eff = LEN_W'(KEY_SLOTS);
    end else begin
      len_eff = LEN_W'(key_length_q);
    end
  end

  // position for this item and the one after it
  always_comb begin
    is_enc  = (req_type_i == REQ_ENCRYPT);
    pos_use = (LEN_W'(pos_q) >= len_eff) ? '0 : pos_q;
    pos_inc = LEN_W'(pos_use) + LEN_W'(1);
    pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[AddrW-1:0];
    idx_ext = LEN_W'(key_index_i);
    pos_d   = pos_q;
    if (accept_i) begin
      pos_d = is_enc ? pos_nxt : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // key read issued at accept of an encrypt item
  assign rd_en_o   = accept_i && is_enc;
  assign rd_addr_o = pos_use;

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_enc_q  <= is_enc;
      s1_wok_q  <= is_enc || (idx_ext < LEN_W'(KEY_SLOTS));
      s1_addr_q <= is_enc ? pos_use : idx_ext[AddrW-1:0];
      s1_val_q  <= letter_value(letter_i);
    end
  end

  // forward the write that landed on the same edge as this read
  always_comb begin
    key_val = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rd_data_i;
    sum_raw = (VAL_W+1)'(s1_val_q) + (VAL_W+1)'(key_val);
    sum     = (sum_raw >= (VAL_W+1)'(ALPHA_COUNT))
              ? VAL_W'(sum_raw - (VAL_W+1)'(ALPHA_COUNT)) : sum_raw[VAL_W-1:0];
  end

  // write-back: ciphertext for encrypt, key letter for load
  assign wr_en_o   = s1_valid_q && s1_wok_q;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = s1_enc_q ? sum : s1_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= wr_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= wr_addr_o;
    fwd_data_q <= wr_data_o;
  end

  // result item
  assign inflight_o           = s1_valid_q && s1_enc_q;
  assign push_o.valid         = s1_valid_q && s1_enc_q;
  assign push_o.cipher_letter = LETTER_W'(sum) + LETTER_W'(UPPER_BASE);

endmodule

FILE: design/cak_outq.sv
module cak_outq import cak_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  input  logic                inflight_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LETTER_W-1:0] out_letter_o
);

  localparam int unsigned PtrW = $clog2(OUTQ_DEPTH);
  localparam int unsigned CntW = $clog2(OUTQ_DEPTH + 1);

  logic [LETTER_W-1:0] slot_q [OUTQ_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  // pointer and count update
  always_comb begin
    pop      = out_valid_o && out_ready_i;
    wr_ptr_d = push_i.valid ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i.valid) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.cipher_letter;
    end
  end

  // room for everything queued, in stage 1, and one more item
  assign in_ready_o   = ((CntW+1)'(cnt_q) + (CntW+1)'(inflight_i)) < (CntW+1)'(OUTQ_DEPTH);
  assign out_valid_o  = (cnt_q != '0);
  assign out_letter_o = slot_q[rd_ptr_q];

endmodule

FILE: design/ciphertext_autokey_stream_cipher.sv
// path: an accepted encrypt item passes the stage 1 register and then the result queue before its result is valid
// throughput: one item per cycle sustained while the result queue has room, load or encrypt, any mix
// the key ram read at accept and its write-back in the next cycle set that rate,
// with a one-entry forward covering back-to-back use of the same slot
// reset: position 0, key length 1, result queue empty; key ram is not cleared
module ciphertext_autokey_stream_cipher import cak_pkg::*; #(
  parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  cak_req_if.sink          req_i,
  cak_res_if.source        res_o
);

  localparam int unsigned AddrW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic             accept;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             inflight;
  push_t            push;

  // input handshake
  assign accept = req_i.valid && req_i.ready;

  // key ring storage
  cak_keyram #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_keyram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // position tracking, read-modify-write of the ring
  cak_engine #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .req_type_i  (req_i.req_type),
    .key_index_i (req_i.key_index),
    .letter_i    (req_i.letter),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .inflight_o  (inflight),
    .push_o      (push)
  );

  // result queue, decouples the output stall from input acceptance
  cak_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .inflight_i   (inflight),
    .in_ready_o   (req_i.ready),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .out_letter_o (res_o.cipher_letter)
  );

endmodule

FILE: design/cak_checker.sv
`include "ciphertext_autokey_stream_cipher_defines.svh"

module cak_checker import cak_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                req_type_i,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input logic [LETTER_W-1:0] res_letter_i
);

  logic [3:0] pend_q;
  logic       enc_acc;
  logic       res_acc;

  // encrypt items accepted but not yet delivered
  assign enc_acc = req_valid_i && req_ready_i && (req_type_i == REQ_ENCRYPT);
  assign res_acc = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(enc_acc) - 4'(res_acc);
    end
  end

  // every result is an uppercase letter
  `CAK_ASSERT_IMP(a_letter_range, res_valid_i, res_letter_i >= LETTER_W'(UPPER_BASE) && res_letter_i <= LETTER_W'(UPPER_BASE + ALPHA_COUNT - 1), "result letter outside A-Z")

  // no result without an encrypt item waiting for it
  `CAK_ASSERT_IMP(a_no_spurious, pend_q == 4'd0, !res_valid_i, "result with no pending encrypt item")

  // a stalled result holds
  `CAK_ASSERT_NXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_letter_i), "stalled result changed")

endmodule

bind ciphertext_autokey_stream_cipher cak_checker u_cak_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_letter_i (res_o.cipher_letter)
);
